FILE: rtl/qsp_pkg.sv
// Shared types and constants for the quadrature sweep positioner.
// No dependencies; every other file of the block refers to this package by scoped name.
`default_nettype none

package qsp_pkg;

    // One encoder sample
    typedef struct packed {
        logic enc_a;
        logic enc_b;
        logic ms_tick;
    } qsp_in_t;

    // One result item
    typedef struct packed {
        logic [9:0]         fwd_level;
        logic [9:0]         rev_level;
        logic signed [23:0] position;
        logic [5:0]         current_stop;
        logic               seeking;
        logic               stop_reached;
    } qsp_out_t;

    // Register file contents as seen by the datapath
    typedef struct packed {
        logic [5:0]  stop_count;
        logic [15:0] stop_interval;
        logic [15:0] tolerance;
        logic [15:0] slowdown_window;
        logic [9:0]  cruise_level;
        logic [9:0]  approach_level;
        logic [15:0] dwell_ticks;
    } qsp_cfg_t;

    // Register word index (byte address / 4)
    typedef enum logic [2:0] {
        REG_STOP_COUNT      = 3'd0,
        REG_STOP_INTERVAL   = 3'd1,
        REG_TOLERANCE       = 3'd2,
        REG_SLOWDOWN_WINDOW = 3'd3,
        REG_CRUISE_LEVEL    = 3'd4,
        REG_APPROACH_LEVEL  = 3'd5,
        REG_DWELL_TICKS     = 3'd6
    } reg_idx_t;

    localparam int AddrWidth = 5;

    // Register reset values
    localparam logic [5:0]  StopCountRst      = 6'd20;
    localparam logic [15:0] StopIntervalRst   = 16'd53;
    localparam logic [15:0] ToleranceRst      = 16'd6;
    localparam logic [15:0] SlowdownWindowRst = 16'd26;
    localparam logic [9:0]  CruiseLevelRst    = 10'd1000;
    localparam logic [9:0]  ApproachLevelRst  = 10'd550;
    localparam logic [15:0] DwellTicksRst     = 16'd1000;

    // x4 quadrature step, indexed by {previous A, previous B, A, B}
    localparam logic signed [1:0] QuadTable [16] = '{
         2'sd0, -2'sd1,  2'sd1,  2'sd0,
         2'sd1,  2'sd0,  2'sd0, -2'sd1,
        -2'sd1,  2'sd0,  2'sd0,  2'sd1,
         2'sd0,  2'sd1, -2'sd1,  2'sd0
    };

endpackage

`default_nettype wire

FILE: rtl/qsp_regs.sv
// APB-style configuration register file for the quadrature sweep positioner.
// Depends on qsp_pkg for the register index codes, reset values and the config struct.
`default_nettype none

module qsp_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [qsp_pkg::AddrWidth-1:0]  paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    output qsp_pkg::qsp_cfg_t                   cfg
);

    qsp_pkg::qsp_cfg_t cfg_reg;
    qsp_pkg::reg_idx_t idx;
    logic              wr_en;

    assign pready = 1'b1;
    assign idx    = qsp_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    // Write on the access phase of a write transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stop_count      <= qsp_pkg::StopCountRst;
            cfg_reg.stop_interval   <= qsp_pkg::StopIntervalRst;
            cfg_reg.tolerance       <= qsp_pkg::ToleranceRst;
            cfg_reg.slowdown_window <= qsp_pkg::SlowdownWindowRst;
            cfg_reg.cruise_level    <= qsp_pkg::CruiseLevelRst;
            cfg_reg.approach_level  <= qsp_pkg::ApproachLevelRst;
            cfg_reg.dwell_ticks     <= qsp_pkg::DwellTicksRst;
        end
        else if (wr_en)
        begin
            unique case (idx)
                qsp_pkg::REG_STOP_COUNT:      cfg_reg.stop_count      <= pwdata[5:0];
                qsp_pkg::REG_STOP_INTERVAL:   cfg_reg.stop_interval   <= pwdata[15:0];
                qsp_pkg::REG_TOLERANCE:       cfg_reg.tolerance       <= pwdata[15:0];
                qsp_pkg::REG_SLOWDOWN_WINDOW: cfg_reg.slowdown_window <= pwdata[15:0];
                qsp_pkg::REG_CRUISE_LEVEL:    cfg_reg.cruise_level    <= pwdata[9:0];
                qsp_pkg::REG_APPROACH_LEVEL:  cfg_reg.approach_level  <= pwdata[9:0];
                qsp_pkg::REG_DWELL_TICKS:     cfg_reg.dwell_ticks     <= pwdata[15:0];
                default:                      ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (idx)
            qsp_pkg::REG_STOP_COUNT:      prdata = {26'd0, cfg_reg.stop_count};
            qsp_pkg::REG_STOP_INTERVAL:   prdata = {16'd0, cfg_reg.stop_interval};
            qsp_pkg::REG_TOLERANCE:       prdata = {16'd0, cfg_reg.tolerance};
            qsp_pkg::REG_SLOWDOWN_WINDOW: prdata = {16'd0, cfg_reg.slowdown_window};
            qsp_pkg::REG_CRUISE_LEVEL:    prdata = {22'd0, cfg_reg.cruise_level};
            qsp_pkg::REG_APPROACH_LEVEL:  prdata = {22'd0, cfg_reg.approach_level};
            qsp_pkg::REG_DWELL_TICKS:     prdata = {16'd0, cfg_reg.dwell_ticks};
            default:                      prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/qsp_core.sv
// Per-sample datapath: x4 quadrature decode and the dwell/seek sweep state.
// Depends on qsp_pkg for the sample, result and config types and the decode table.
`default_nettype none

module qsp_core #(
    parameter int COUNT_WIDTH = 24
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               advance,
    input  wire qsp_pkg::qsp_in_t   sample,
    input  wire qsp_pkg::qsp_cfg_t  cfg,
    output qsp_pkg::qsp_out_t       result
);

    localparam int W = COUNT_WIDTH;
    localparam logic signed [W+1:0] CountMax = {3'b000, {(W-1){1'b1}}};
    localparam logic signed [W+1:0] CountMin = {3'b111, {(W-1){1'b0}}};

    function automatic logic signed [W-1:0] sat_count(input logic signed [W+1:0] v);
        logic signed [W+1:0] r;
        begin
            r = v;
            if (v > CountMax)
                r = CountMax;
            else if (v < CountMin)
                r = CountMin;
            return r[W-1:0];
        end
    endfunction

    // Sweep state
    logic [1:0]          prev_pins_reg;
    logic                primed_reg;
    logic signed [W-1:0] count_reg, count_next;
    logic                phase_seek_reg, phase_seek_next;
    logic [15:0]         dwell_reg, dwell_next;
    logic [5:0]          stop_reg, stop_next;
    logic                going_down_reg, going_down_next;
    logic signed [W-1:0] target_reg, target_next;

    logic [1:0]          pins;
    logic signed [1:0]   step;
    logic signed [W+1:0] cnt_sum;

    logic [15:0]         dwell_inc;
    logic                dwell_done;

    logic signed [7:0]   idx_s, sc_s, idx_n0, idx_n1;
    logic                gd_adv;
    logic signed [W+1:0] count_ext, ivl_ext, tgt_sum;
    logic signed [W-1:0] target_adv;

    logic signed [W:0]   err;
    logic [W:0]          mag;
    logic                within_tol, near, err_pos;
    logic [9:0]          lvl, fwd, rev;
    logic                reached;
    logic signed [31:0]  pos_ext;

    // Decode the quadrature transition; the first sample only primes the pins
    assign pins    = {sample.enc_a, sample.enc_b};
    assign step    = qsp_pkg::QuadTable[{prev_pins_reg, pins}];
    assign cnt_sum = (W+2)'(count_reg) + (W+2)'(step);
    assign count_next = primed_reg ? sat_count(cnt_sum) : count_reg;

    // Dwell timer, saturating at full scale
    assign dwell_inc  = (sample.ms_tick && dwell_reg != 16'hFFFF) ? dwell_reg + 16'd1 : dwell_reg;
    assign dwell_done = dwell_inc >= cfg.dwell_ticks;

    // Step the stop index, bouncing at both ends, then clamp
    always_comb
    begin
        idx_s  = {2'b00, stop_reg};
        sc_s   = {2'b00, cfg.stop_count};
        idx_n0 = going_down_reg ? idx_s - 8'sd1 : idx_s + 8'sd1;
        gd_adv = going_down_reg;
        idx_n1 = idx_n0;
        if (idx_n0 > sc_s)
        begin
            gd_adv = 1'b1;
            idx_n1 = idx_s - 8'sd1;
        end
        else if (idx_n0 < 8'sd0)
        begin
            gd_adv = 1'b0;
            idx_n1 = idx_s + 8'sd1;
        end
        if (idx_n1 < 8'sd0)
            idx_n1 = 8'sd0;
        if (idx_n1 > sc_s)
            idx_n1 = sc_s;
    end

    // New target one interval away from the present position
    assign count_ext  = (W+2)'(count_next);
    assign ivl_ext    = (W+2)'({1'b0, cfg.stop_interval});
    assign tgt_sum    = gd_adv ? count_ext - ivl_ext : count_ext + ivl_ext;
    assign target_adv = sat_count(tgt_sum);

    // Position error and drive level
    assign err        = (W+1)'(target_reg) - (W+1)'(count_next);
    assign mag        = err[W] ? (W+1)'(-err) : (W+1)'(err);
    assign within_tol = mag <= (W+1)'(cfg.tolerance);
    assign near       = mag <= (W+1)'(cfg.slowdown_window);
    assign err_pos    = !err[W] && (err != '0);
    assign lvl        = near ? cfg.approach_level : cfg.cruise_level;

    // Dwell/seek sequencing
    always_comb
    begin
        phase_seek_next = phase_seek_reg;
        dwell_next      = dwell_reg;
        stop_next       = stop_reg;
        going_down_next = going_down_reg;
        target_next     = target_reg;
        fwd             = 10'd0;
        rev             = 10'd0;
        reached         = 1'b0;
        if (!phase_seek_reg)
        begin
            dwell_next = dwell_inc;
            if (dwell_done)
            begin
                stop_next       = idx_n1[5:0];
                going_down_next = gd_adv;
                target_next     = target_adv;
                phase_seek_next = 1'b1;
                dwell_next      = 16'd0;
            end
        end
        else if (within_tol)
        begin
            phase_seek_next = 1'b0;
            dwell_next      = 16'd0;
            reached         = 1'b1;
        end
        else if (err_pos)
            fwd = lvl;
        else
            rev = lvl;
    end

    // Result of the sample now in the input register
    assign pos_ext = 32'(count_next);

    always_comb
    begin
        result.fwd_level    = fwd;
        result.rev_level    = rev;
        result.position     = pos_ext[23:0];
        result.current_stop = stop_next;
        result.seeking      = phase_seek_next;
        result.stop_reached = reached;
    end

    // Commit the state when the sample moves on to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_pins_reg  <= 2'b00;
            primed_reg     <= 1'b0;
            count_reg      <= '0;
            phase_seek_reg <= 1'b0;
            dwell_reg      <= 16'd0;
            stop_reg       <= 6'd0;
            going_down_reg <= 1'b0;
            target_reg     <= '0;
        end
        else if (advance)
        begin
            prev_pins_reg  <= pins;
            primed_reg     <= 1'b1;
            count_reg      <= count_next;
            phase_seek_reg <= phase_seek_next;
            dwell_reg      <= dwell_next;
            stop_reg       <= stop_next;
            going_down_reg <= going_down_next;
            target_reg     <= target_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/quadrature_sweep_positioner.sv
// Top level of the quadrature sweep positioner: sample register, datapath, result register.
// Depends on qsp_pkg, qsp_regs and qsp_core.
`default_nettype none

// The block takes one encoder sample per clock while results are taken and returns one
// result per sample, in order. A sample is held in an input register, runs through the
// decode and sweep logic and is registered in the result register when it moves on,
// which waits while an untaken result is held. Throughput is one sample per cycle when
// results are taken; qsp_core updates the position, dwell timer and target state as each
// sample moves on, and the input side stalls only while a sample and a result are both
// held and the result is not taken. Position saturates at the limits of a COUNT_WIDTH-bit
// signed count and is reported as its low 24 bits of the sign-extended value. Registers
// sit on an APB-style port at byte addresses 0x00 to 0x18 and should be written only
// while no sample is in flight.
module quadrature_sweep_positioner #(
    parameter int COUNT_WIDTH = 24
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [qsp_pkg::AddrWidth-1:0]  paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  wire logic                           sample_valid,
    output logic                                sample_ready,
    input  wire qsp_pkg::qsp_in_t               sample,
    output logic                                result_valid,
    input  wire logic                           result_ready,
    output qsp_pkg::qsp_out_t                   result
);

    qsp_pkg::qsp_cfg_t cfg;
    qsp_pkg::qsp_in_t  s1_data_reg;
    logic              s1_valid_reg;
    qsp_pkg::qsp_out_t core_result;
    qsp_pkg::qsp_out_t result_data_reg;
    logic              result_valid_reg;
    logic              advance;

    qsp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    qsp_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .sample  (s1_data_reg),
        .cfg     (cfg),
        .result  (core_result)
    );

    // Move the held sample on whenever the result register is free or being drained
    assign advance      = s1_valid_reg && (!result_valid_reg || result_ready);
    assign sample_ready = !s1_valid_reg || advance;
    assign result_valid = result_valid_reg;
    assign result       = result_data_reg;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (sample_ready)
            s1_valid_reg <= sample_valid;
    end

    always_ff @(posedge clk)
    begin
        if (sample_valid && sample_ready)
            s1_data_reg <= sample;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (advance)
            result_valid_reg <= 1'b1;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_data_reg <= core_result;
    end

`ifndef SYNTHESIS
    a_drive_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (result_data_reg.fwd_level == 10'd0
                              || result_data_reg.rev_level == 10'd0))
        else $error("forward and reverse driven together");

    a_dwell_no_drive: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !result_data_reg.seeking)
            |-> (result_data_reg.fwd_level == 10'd0 && result_data_reg.rev_level == 10'd0))
        else $error("motor driven during dwell");

    a_reached_ends_seek: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_data_reg.stop_reached) |-> !result_data_reg.seeking)
        else $error("stop reached while still seeking");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !sample_ready |-> (s1_valid_reg && result_valid_reg && !result_ready))
        else $error("input stalled without a full pipeline");

    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_valid_reg)
        else $error("advanced sample produced no result");
`endif

endmodule

`default_nettype wire

FILE: verif/positioner_checker.sv
// Checker for the quadrature sweep positioner: watches the register port and both
// sample channels, predicts each result and compares it with what the block returns.
// Depends on qsp_pkg for the payload, register and index types.

module positioner_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [qsp_pkg::AddrWidth-1:0]  paddr,
    input  logic [31:0]                    pwdata,
    input  logic                           pready,
    input  logic                           sample_valid,
    input  logic                           sample_ready,
    input  qsp_pkg::qsp_in_t               sample,
    input  logic                           result_valid,
    input  logic                           result_ready,
    input  qsp_pkg::qsp_out_t              result,
    output int                             mismatches,
    output int                             outstanding,
    output int                             stops_hit
);

    localparam int CountMax    = 8388607;
    localparam int CountMin    = -8388608;
    localparam int ElapsedMax  = 65535;
    localparam int ReportLimit = 10;

    // stop_count, stop_interval, tolerance, slowdown_window, cruise, approach, dwell
    localparam qsp_pkg::qsp_cfg_t SettingAtReset =
        {6'd20, 16'd53, 16'd6, 16'd26, 10'd1000, 10'd550, 16'd1000};

    qsp_pkg::qsp_cfg_t setting;

    // Shadow of the block's sweep state
    logic [1:0] last_pins;
    logic       primed;
    int         pos;
    logic       seeking;
    int         dwell_cnt;
    int         stop_idx;
    logic       heading_down;
    int         goal;

    qsp_pkg::qsp_out_t awaited_results [$];

    int fail_count   = 0;
    int queued_count = 0;
    int reached_seen = 0;

    assign mismatches  = fail_count;
    assign outstanding = queued_count;
    assign stops_hit   = reached_seen;

    function automatic int clamp_count(input int v);
        if (v > CountMax)
            return CountMax;
        if (v < CountMin)
            return CountMin;
        return v;
    endfunction

    // x4 decode of {previous A, previous B, A, B}; a jump of both pins counts as nothing
    function automatic int quad_delta(input logic [3:0] move);
        case (move)
            4'b0010, 4'b1011, 4'b1101, 4'b0100: return 1;
            4'b0001, 4'b0111, 4'b1110, 4'b1000: return -1;
            default: return 0;
        endcase
    endfunction

    // Update the encoder count, then run one step of the dwell/seek sweep
    task automatic predict_sample(input qsp_pkg::qsp_in_t s, output qsp_pkg::qsp_out_t r);
        logic [1:0] pins;
        int         limit;
        int         step_len;
        int         err;
        int         mag;
        int         nxt;
        int         tol;
        int         win;
        int         dwell_len;
        logic [9:0] lvl;
        begin
            pins      = {s.enc_a, s.enc_b};
            limit     = setting.stop_count;
            step_len  = setting.stop_interval;
            tol       = setting.tolerance;
            win       = setting.slowdown_window;
            dwell_len = setting.dwell_ticks;
            r         = '0;

            if (primed)
                pos = clamp_count(pos + quad_delta({last_pins, pins}));
            primed    = 1'b1;
            last_pins = pins;

            if (!seeking) begin
                if (s.ms_tick && dwell_cnt < ElapsedMax)
                    dwell_cnt++;
                if (dwell_cnt >= dwell_len) begin
                    // bounce the stop index between 0 and the stop count
                    nxt = stop_idx + (heading_down ? -1 : 1);
                    if (nxt > limit) begin
                        heading_down = 1'b1;
                        nxt = stop_idx - 1;
                    end else if (nxt < 0) begin
                        heading_down = 1'b0;
                        nxt = stop_idx + 1;
                    end
                    if (nxt < 0)
                        nxt = 0;
                    if (nxt > limit)
                        nxt = limit;
                    stop_idx  = nxt;
                    goal      = clamp_count(heading_down ? pos - step_len : pos + step_len);
                    seeking   = 1'b1;
                    dwell_cnt = 0;
                end
            end else begin
                err = goal - pos;
                mag = (err < 0) ? -err : err;
                if (mag <= tol) begin
                    seeking        = 1'b0;
                    dwell_cnt      = 0;
                    r.stop_reached = 1'b1;
                end else begin
                    lvl = (mag <= win) ? setting.approach_level : setting.cruise_level;
                    if (err > 0)
                        r.fwd_level = lvl;
                    else
                        r.rev_level = lvl;
                end
            end

            r.position     = pos[23:0];
            r.current_stop = stop_idx[5:0];
            r.seeking      = seeking;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        qsp_pkg::qsp_out_t want;
        qsp_pkg::qsp_out_t fresh;
        if (!rst_n) begin
            setting      = SettingAtReset;
            last_pins    = 2'b00;
            primed       = 1'b0;
            pos          = 0;
            seeking      = 1'b0;
            dwell_cnt    = 0;
            stop_idx     = 0;
            heading_down = 1'b0;
            goal         = 0;
            awaited_results.delete();
            queued_count = 0;
        end else begin
            // Track register writes
            if (psel && penable && pwrite && pready) begin
                case (qsp_pkg::reg_idx_t'(paddr[qsp_pkg::AddrWidth-1:2]))
                    qsp_pkg::REG_STOP_COUNT:      setting.stop_count      = pwdata[5:0];
                    qsp_pkg::REG_STOP_INTERVAL:   setting.stop_interval   = pwdata[15:0];
                    qsp_pkg::REG_TOLERANCE:       setting.tolerance       = pwdata[15:0];
                    qsp_pkg::REG_SLOWDOWN_WINDOW: setting.slowdown_window = pwdata[15:0];
                    qsp_pkg::REG_CRUISE_LEVEL:    setting.cruise_level    = pwdata[9:0];
                    qsp_pkg::REG_APPROACH_LEVEL:  setting.approach_level  = pwdata[9:0];
                    qsp_pkg::REG_DWELL_TICKS:     setting.dwell_ticks     = pwdata[15:0];
                    default: ;
                endcase
            end

            // Compare each returned transaction with the oldest prediction
            if (result_valid && result_ready) begin
                if (awaited_results.size() == 0) begin
                    if (fail_count < ReportLimit)
                        $display("unexpected result at %0t: fwd=%0d rev=%0d pos=%0d stop=%0d",
                                 $time, result.fwd_level, result.rev_level, result.position,
                                 result.current_stop);
                    fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    if (result.fwd_level !== want.fwd_level ||
                        result.rev_level !== want.rev_level ||
                        result.position !== want.position ||
                        result.current_stop !== want.current_stop ||
                        result.seeking !== want.seeking ||
                        result.stop_reached !== want.stop_reached) begin
                        if (fail_count < ReportLimit) begin
                            $display("mismatch at %0t: expected fwd=%0d rev=%0d pos=%0d stop=%0d seek=%0b hit=%0b",
                                     $time, want.fwd_level, want.rev_level, want.position,
                                     want.current_stop, want.seeking, want.stop_reached);
                            $display("                 actual fwd=%0d rev=%0d pos=%0d stop=%0d seek=%0b hit=%0b",
                                     result.fwd_level, result.rev_level, result.position,
                                     result.current_stop, result.seeking, result.stop_reached);
                        end
                        fail_count++;
                    end
                end
            end

            // Predict the result of each accepted sample
            if (sample_valid && sample_ready) begin
                predict_sample(sample, fresh);
                awaited_results.push_back(fresh);
                if (fresh.stop_reached)
                    reached_seen++;
            end

            queued_count = awaited_results.size();
        end
    end

endmodule

FILE: verif/testbench.sv
// Top of the quadrature sweep positioner testbench: clock, reset, register writes,
// encoder stimulus that follows the motor drive, and the final verdict.
// Depends on qsp_pkg, quadrature_sweep_positioner and positioner_checker.

module testbench;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    localparam int CycleLimit = 400000;
    localparam int DrainWait  = 4;

    // Directed encoder walk: a priming sample, then every one of the 16 pin transitions
    localparam logic [35:0] DirectedPins = {2'd2, 2'd0, 2'd0, 2'd1, 2'd0, 2'd2, 2'd0, 2'd3,
                                            2'd1, 2'd1, 2'd2, 2'd1, 2'd3, 2'd2, 2'd2, 2'd3,
                                            2'd3, 2'd0};

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                          psel    = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite  = 1'b0;
    logic [qsp_pkg::AddrWidth-1:0] paddr   = '0;
    logic [31:0]                   pwdata  = '0;
    logic [31:0]                   prdata;
    logic                          pready;

    logic              sample_valid = 1'b0;
    logic              sample_ready;
    qsp_pkg::qsp_in_t  sample       = '0;
    logic              result_valid;
    logic              result_ready = 1'b1;
    qsp_pkg::qsp_out_t result;

    int mismatches;
    int outstanding;
    int stops_hit;

    int         cycles         = 0;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         drive_dir      = 0;
    int         samples_sent   = 0;
    int         settings_used  = 0;
    logic [1:0] cur_pins       = 2'b00;

    quadrature_sweep_positioner DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    positioner_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .stops_hit    (stops_hit)
    );

    always #2 clk = ~clk;

    // Abort on a hung run
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // Stall the result side at random
    always @(negedge clk)
        result_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Motor model: remember which way the last returned transaction drove
    always @(posedge clk)
        if (result_valid && result_ready)
            drive_dir <= (result.fwd_level != 0) ? 1 : ((result.rev_level != 0) ? -1 : 0);

    // One quadrature step forward or back from the given pin state
    function automatic logic [1:0] gray_step(input logic [1:0] cur, input int dir);
        if (dir > 0)
            case (cur)
                2'b00: return 2'b10;
                2'b10: return 2'b11;
                2'b11: return 2'b01;
                default: return 2'b00;
            endcase
        else
            case (cur)
                2'b00: return 2'b01;
                2'b01: return 2'b11;
                2'b11: return 2'b10;
                default: return 2'b00;
            endcase
    endfunction

    // Mostly follow the drive, with some stalls, back-steps and pin jumps
    function automatic logic [1:0] choose_pins(input logic [1:0] cur, input int dir);
        int roll;
        roll = (dir != 0) ? $urandom_range(99) : $urandom_range(99, 70);
        if (roll < 70)
            return gray_step(cur, dir);
        if (roll < 80)
            return cur;
        if (roll < 90)
            return gray_step(cur, 1);
        if (roll < 96)
            return gray_step(cur, -1);
        return 2'($urandom_range(3));
    endfunction

    function automatic qsp_pkg::qsp_cfg_t random_setting();
        qsp_pkg::qsp_cfg_t s;
        s.stop_count      = 6'($urandom_range(6, 1));
        s.stop_interval   = 16'($urandom_range(10, 1));
        s.tolerance       = 16'($urandom_range(2));
        s.slowdown_window = 16'($urandom_range(12));
        s.cruise_level    = 10'($urandom_range(1023));
        s.approach_level  = 10'($urandom_range(1023));
        s.dwell_ticks     = 16'($urandom_range(3));
        return s;
    endfunction

    // Present one sample and hold it until the block takes it
    task automatic push_sample(input logic [1:0] pins, input logic tick);
        while ($urandom_range(99) < send_idle_pct) begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= qsp_pkg::qsp_in_t'({pins, tick});
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        @(negedge clk);
        samples_sent++;
    endtask

    // Let every outstanding result drain, then pause for the pipeline
    task automatic drain();
        sample_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (DrainWait) @(negedge clk);
    endtask

    task automatic write_reg(input qsp_pkg::reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
    endtask

    task automatic apply_setting(input qsp_pkg::qsp_cfg_t s);
        drain();
        write_reg(qsp_pkg::REG_STOP_COUNT, 32'(s.stop_count));
        write_reg(qsp_pkg::REG_STOP_INTERVAL, 32'(s.stop_interval));
        write_reg(qsp_pkg::REG_TOLERANCE, 32'(s.tolerance));
        write_reg(qsp_pkg::REG_SLOWDOWN_WINDOW, 32'(s.slowdown_window));
        write_reg(qsp_pkg::REG_CRUISE_LEVEL, 32'(s.cruise_level));
        write_reg(qsp_pkg::REG_APPROACH_LEVEL, 32'(s.approach_level));
        write_reg(qsp_pkg::REG_DWELL_TICKS, 32'(s.dwell_ticks));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        settings_used++;
    endtask

    task automatic run_phase(input qsp_pkg::qsp_cfg_t s, input int items,
                             input idle_mode_t mode, input int tick_pct);
        logic [1:0] pins;
        logic       tick;
        apply_setting(s);
        send_idle_pct  = (mode == IDLE_SEND) ? 69 : ((mode == IDLE_BOTH) ? 37 : 0);
        recv_stall_pct = (mode == IDLE_RECV) ? 69 : ((mode == IDLE_BOTH) ? 37 : 0);
        for (int i = 0; i < items; i++) begin
            pins = choose_pins(cur_pins, drive_dir);
            tick = ($urandom_range(99) < tick_pct);
            push_sample(pins, tick);
            cur_pins = pins;
        end
    endtask

    initial begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Priming sample and every transition, reset register values
        for (int i = 17; i >= 0; i--) begin
            push_sample(DirectedPins[2*i +: 2], i[0]);
            cur_pins = DirectedPins[2*i +: 2];
        end

        // Low extremes: single stop, unit interval, zero tolerance and window, no dwell
        run_phase({6'd0, 16'd1, 16'd0, 16'd0, 10'd1000, 10'd0, 16'd0}, 40, IDLE_NONE, 50);
        // High extremes: every stop reached at once, so the index climbs quickly
        run_phase({6'd63, 16'd65535, 16'd65535, 16'd65535, 10'd0, 10'd1023, 16'd0},
                  30, IDLE_SEND, 50);
        // Stop count lowered below the current index
        run_phase({6'd3, 16'd4, 16'd1, 16'd3, 10'd700, 10'd300, 16'd2}, 80, IDLE_BOTH, 70);
        // Longest dwell with a tick on every sample, level above the nominal maximum
        run_phase({6'd5, 16'd3, 16'd0, 16'd2, 10'd1023, 10'd1, 16'd65535},
                  40, IDLE_NONE, 100);

        // Random settings, rotating through the idle patterns
        for (int p = 0; p < 8; p++)
            run_phase(random_setting(), 80, idle_mode_t'(p % 4), $urandom_range(100, 30));

        drain();
        $display("run covered %0d samples under %0d register settings, %0d stops reached",
                 samples_sent, settings_used + 1, stops_hit);
        if (mismatches == 0 && outstanding == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
